### hdl/rdsr_pkg.sv
// ----------------------------------------------------------------------------
// rdsr_pkg
// Shared constants for the rational divide/subtract/reduce block.
// ----------------------------------------------------------------------------
package rdsr_pkg;

  // Default width of each fraction operand.
  localparam int unsigned OPERAND_WIDTH_DEF = 16;

  // Width of the reduced numerator and denominator on the result channel.
  localparam int unsigned RES_WIDTH = 34;

  // Operation codes carried in req_type.
  localparam logic OP_DIVIDE   = 1'b0;
  localparam logic OP_SUBTRACT = 1'b1;

  // Status codes on the result channel.
  localparam logic ST_OK       = 1'b0;
  localparam logic ST_DEN_ZERO = 1'b1;

endpackage

### hdl/rdsr_if.sv
// ----------------------------------------------------------------------------
// rdsr_if
// Valid/ready channels: request beats of two fractions, result beats.
// ----------------------------------------------------------------------------
interface rdsr_req_if #(
  parameter int unsigned OPERAND_WIDTH = rdsr_pkg::OPERAND_WIDTH_DEF
) ();
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic signed [OPERAND_WIDTH-1:0] a_num;
  logic signed [OPERAND_WIDTH-1:0] a_den;
  logic signed [OPERAND_WIDTH-1:0] b_num;
  logic signed [OPERAND_WIDTH-1:0] b_den;

  modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rdsr_rsp_if ();
  import rdsr_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [RES_WIDTH-1:0] res_num;
  logic signed [RES_WIDTH-1:0] res_den;
  logic                        status;

  modport source (output valid, res_num, res_den, status, input ready);
  modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

### hdl/rational_divide_subtract_reduce.sv
// ----------------------------------------------------------------------------
// rational_divide_subtract_reduce
// Divides or subtracts two signed fractions and reduces the result by the
// GCD of the magnitudes, keeping the computed signs.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req_i    in   valid / ready      req_type, a_num, a_den, b_num, b_den
//  rsp_o    out  valid / ready      res_num, res_den, status
//
//  One request beat is taken at a time; ready is low while it is worked on.
//  A beat passes through the products and signs, binary GCD steps on the
//  shared subtractor, and two bit-serial exact divides, one for the
//  numerator and one for the denominator. A zero denominator skips the GCD
//  and divides.
//  The result register lets the next request in while a result waits.
//  Reset is asynchronous, active low, and clears the sequencer and valid.
// ----------------------------------------------------------------------------
module rational_divide_subtract_reduce #(
  parameter int unsigned OPERAND_WIDTH = rdsr_pkg::OPERAND_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rdsr_req_if.sink   req_i,
  rdsr_rsp_if.source rsp_o
);
  import rdsr_pkg::*;

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned MW = PW;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned CW = $clog2(MW);
  localparam int unsigned XW = (MW > RES_WIDTH) ? MW : RES_WIDTH;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_MUL0 = 12'b0000_0000_0010,
    S_MUL1 = 12'b0000_0000_0100,
    S_MUL2 = 12'b0000_0000_1000,
    S_NUM  = 12'b0000_0001_0000,
    S_NABS = 12'b0000_0010_0000,
    S_DABS = 12'b0000_0100_0000,
    S_SHR  = 12'b0000_1000_0000,
    S_GCD  = 12'b0001_0000_0000,
    S_DIVN = 12'b0010_0000_0000,
    S_DIVD = 12'b0100_0000_0000,
    S_DONE = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Operand registers.
  logic                req_type_q, req_type_d;
  logic signed [W-1:0] an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;

  // Products, signed values and magnitudes.
  logic signed [PW-1:0] p_q, p_d, q_q, q_d;
  logic [SW-1:0]        nsig_q, nsig_d, dsig_q, dsig_d;
  logic [MW-1:0]        num_q, num_d, den_q, den_d, u_q, u_d, v_q, v_d;
  logic                 nneg_q, nneg_d, dneg_q, dneg_d, zero_q, zero_d;
  logic [SW-1:0]        rem_q, rem_d;
  logic [CW-1:0]        cnt_q, cnt_d;

  // Result register.
  logic                        rsp_valid_q, rsp_valid_d;
  logic signed [RES_WIDTH-1:0] res_num_q, res_num_d, res_den_q, res_den_d;
  logic                        status_q, status_d;

  // Shared units.
  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic [SW-1:0]        sub_a, sub_b, sub_diff, rem_sh;
  logic                 sub_borrow, dvd_msb;
  logic [XW-1:0]        num_x, den_x;
  logic [RES_WIDTH-1:0] num_t, den_t;

  rdsr_mul #(.OPERAND_WIDTH(W)) u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  rdsr_sub #(.WIDTH(SW)) u_sub (
    .a_i      (sub_a),
    .b_i      (sub_b),
    .diff_o   (sub_diff),
    .borrow_o (sub_borrow)
  );

  // Multiplier operand select: a_num*b_den, a_den*b_num, a_den*b_den.
  always_comb begin
    mul_a = an_q;
    mul_b = bd_q;
    case (state_q)
      S_MUL1: begin
        mul_a = ad_q;
        mul_b = bn_q;
      end
      S_MUL2: begin
        mul_a = ad_q;
        mul_b = bd_q;
      end
      default: begin
      end
    endcase
  end

  // Restoring-divide trial remainder brings in the next dividend bit.
  assign dvd_msb = (state_q == S_DIVN) ? num_q[MW-1] : den_q[MW-1];
  assign rem_sh  = {rem_q[SW-2:0], dvd_msb};

  // Subtractor operand select.
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (state_q)
      S_NUM: begin
        sub_a = {p_q[PW-1], p_q};
        sub_b = {q_q[PW-1], q_q};
      end
      S_NABS: sub_b = nsig_q;
      S_DABS: sub_b = dsig_q;
      S_GCD: begin
        sub_a = {1'b0, u_q};
        sub_b = {1'b0, v_q};
      end
      S_DIVN, S_DIVD: begin
        sub_a = rem_sh;
        sub_b = {1'b0, v_q};
      end
      default: begin
      end
    endcase
  end

  // Quotients sized to the result width, then signed as computed.
  assign num_x = XW'(num_q);
  assign den_x = XW'(den_q);
  assign num_t = num_x[RES_WIDTH-1:0];
  assign den_t = den_x[RES_WIDTH-1:0];

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    req_type_d  = req_type_q;
    an_d        = an_q;
    ad_d        = ad_q;
    bn_d        = bn_q;
    bd_d        = bd_q;
    p_d         = p_q;
    q_d         = q_q;
    nsig_d      = nsig_q;
    dsig_d      = dsig_q;
    num_d       = num_q;
    den_d       = den_q;
    u_d         = u_q;
    v_d         = v_q;
    nneg_d      = nneg_q;
    dneg_d      = dneg_q;
    zero_d      = zero_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    res_num_d   = res_num_q;
    res_den_d   = res_den_q;
    status_d    = status_q;
    rsp_valid_d = rsp_valid_q;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          req_type_d = req_i.req_type;
          an_d       = req_i.a_num;
          ad_d       = req_i.a_den;
          bn_d       = req_i.b_num;
          bd_d       = req_i.b_den;
          state_d    = S_MUL0;
        end
      end
      S_MUL0: state_d = S_MUL1;
      S_MUL1: begin
        p_d     = prod;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        q_d     = prod;
        state_d = S_NUM;
      end
      S_NUM: begin
        if (req_type_q == OP_SUBTRACT) begin
          nsig_d = sub_diff;
          dsig_d = {prod[PW-1], prod};
        end else begin
          nsig_d = {p_q[PW-1], p_q};
          dsig_d = {q_q[PW-1], q_q};
        end
        state_d = S_NABS;
      end
      S_NABS: begin
        nneg_d  = nsig_q[SW-1];
        num_d   = nsig_q[SW-1] ? sub_diff[MW-1:0] : nsig_q[MW-1:0];
        state_d = S_DABS;
      end
      S_DABS: begin
        dneg_d  = dsig_q[SW-1];
        den_d   = dsig_q[SW-1] ? sub_diff[MW-1:0] : dsig_q[MW-1:0];
        zero_d  = (dsig_q == '0);
        u_d     = num_q;
        v_d     = den_d;
        state_d = (dsig_q == '0) ? S_DONE : S_SHR;
      end
      // Strip common factors of two from both values and the GCD pair.
      S_SHR: begin
        if (!u_q[0] && !v_q[0]) begin
          u_d   = u_q >> 1;
          v_d   = v_q >> 1;
          num_d = num_q >> 1;
          den_d = den_q >> 1;
        end else begin
          state_d = S_GCD;
        end
      end
      // Binary GCD on the odd part; v holds the GCD once u reaches zero.
      S_GCD: begin
        if (u_q == '0) begin
          rem_d   = '0;
          cnt_d   = CW'(MW - 1);
          state_d = S_DIVN;
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (sub_borrow) begin
          u_d = v_q;
          v_d = u_q;
        end else begin
          u_d = {1'b0, sub_diff[MW-1:1]};
        end
      end
      // Exact divides, one quotient bit per cycle, quotient shifts in place.
      S_DIVN: begin
        rem_d = sub_borrow ? rem_sh : sub_diff;
        num_d = {num_q[MW-2:0], ~sub_borrow};
        if (cnt_q == '0) begin
          rem_d   = '0;
          cnt_d   = CW'(MW - 1);
          state_d = S_DIVD;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_DIVD: begin
        rem_d = sub_borrow ? rem_sh : sub_diff;
        den_d = {den_q[MW-2:0], ~sub_borrow};
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          if (zero_q) begin
            res_num_d = '0;
            res_den_d = '0;
            status_d  = ST_DEN_ZERO;
          end else begin
            res_num_d = nneg_q ? -num_t : num_t;
            res_den_d = dneg_q ? -den_t : den_t;
            status_d  = ST_OK;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    req_type_q <= req_type_d;
    an_q       <= an_d;
    ad_q       <= ad_d;
    bn_q       <= bn_d;
    bd_q       <= bd_d;
    p_q        <= p_d;
    q_q        <= q_d;
    nsig_q     <= nsig_d;
    dsig_q     <= dsig_d;
    num_q      <= num_d;
    den_q      <= den_d;
    u_q        <= u_d;
    v_q        <= v_d;
    nneg_q     <= nneg_d;
    dneg_q     <= dneg_d;
    zero_q     <= zero_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    res_num_q  <= res_num_d;
    res_den_q  <= res_den_d;
    status_q   <= status_d;
  end

  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.res_num = res_num_q;
  assign rsp_o.res_den = res_den_q;
  assign rsp_o.status  = status_q;

endmodule

### hdl/rdsr_mul.sv
// ----------------------------------------------------------------------------
// rdsr_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module rdsr_mul #(
  parameter int unsigned OPERAND_WIDTH = rdsr_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic signed [OPERAND_WIDTH-1:0]   a_i,
  input  logic signed [OPERAND_WIDTH-1:0]   b_i,
  output logic signed [2*OPERAND_WIDTH-1:0] prod_o
);
  import rdsr_pkg::*;

  logic signed [2*OPERAND_WIDTH-1:0] prod_q;

  // One product per cycle; the register breaks the path to the sequencer.
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

### hdl/rdsr_sub.sv
// ----------------------------------------------------------------------------
// rdsr_sub
// Shared subtract/compare unit used for the numerator difference, sign handling, GCD and division.
// ----------------------------------------------------------------------------
module rdsr_sub #(
  parameter int unsigned WIDTH = 2 * rdsr_pkg::OPERAND_WIDTH_DEF + 1
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  output logic [WIDTH-1:0] diff_o,
  output logic             borrow_o
);
  import rdsr_pkg::*;

  // The extra top bit gives the unsigned borrow, i.e. a_i < b_i.
  assign {borrow_o, diff_o} = {1'b0, a_i} - {1'b0, b_i};

endmodule

### hdl/rdsr_chk.sv
// ----------------------------------------------------------------------------
// rdsr_chk
// Port-level checks for the rational divide/subtract/reduce block.
// ----------------------------------------------------------------------------
module rdsr_chk (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  req_valid_i,
  input logic                                  req_ready_i,
  input logic                                  rsp_valid_i,
  input logic                                  rsp_ready_i,
  input logic signed [rdsr_pkg::RES_WIDTH-1:0] res_num_i,
  input logic signed [rdsr_pkg::RES_WIDTH-1:0] res_den_i,
  input logic                                  status_i
);
  import rdsr_pkg::*;

  // A request beat keeps the block busy for at least the following cycle.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while the previous one is still in work");

  // An undefined fraction is reported as zero over zero.
  a_zero_den_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == ST_DEN_ZERO |-> res_num_i == '0 && res_den_i == '0)
    else $error("zero-denominator result carries nonzero fields");

  // A zero numerator reduces to a denominator of plus or minus one.
  a_zero_num_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == ST_OK && res_num_i == '0
      |-> res_den_i == RES_WIDTH'(1) || res_den_i == '1)
    else $error("zero numerator not reduced to a unit denominator");

  // A good result never has a zero denominator.
  a_ok_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == ST_OK |-> res_den_i != '0)
    else $error("good result with zero denominator");

  // A stalled result beat holds.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(res_num_i)
      && $stable(res_den_i) && $stable(status_i))
    else $error("result beat changed while stalled");

endmodule

bind rational_divide_subtract_reduce rdsr_chk u_rdsr_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .res_num_i   (rsp_o.res_num),
  .res_den_i   (rsp_o.res_den),
  .status_i    (rsp_o.status)
);
